@@ rtl/core/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register indexes and constants for the environmental
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_T   = 3'd0,
        REG_CALIB_PLO = 3'd1,
        REG_CALIB_PHI = 3'd2,
        REG_CALIB_MIX = 3'd3,
        REG_CALIB_HUM = 3'd4,
        REG_HUM_EN    = 3'd5
    } t_cfg_idx;

    // pipeline geometry
    localparam int NUM_W      = 64;               // dividend / quotient width
    localparam int DEN_W      = 31;               // divisor width (signed)
    localparam int DIV_STEPS  = NUM_W;            // one quotient bit per stage
    localparam int DIV_LAT    = DIV_STEPS + 2;    // abs stage + steps + sign stage
    localparam int TEMP_STAGE = 4;                // stage holding the centi result
    localparam int FRONT_LAT  = 12;               // stages up to the divider
    localparam int HUM_LAT    = 9;
    localparam int HUM_STAGE  = TEMP_STAGE + HUM_LAT;
    localparam int BACK_LAT   = 6;
    localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT;
    localparam int TC_DLY     = TOTAL_LAT - TEMP_STAGE - 1;
    localparam int HUM_DLY    = TOTAL_LAT - HUM_STAGE - 1;

    // arithmetic constants
    localparam logic [31:0] T_ROUND     = 32'd128;
    localparam logic [32:0] P_OFFSET_T  = 33'd128000;
    localparam logic [20:0] P_BASE      = 21'd1048576;
    localparam logic [11:0] P_SCALE     = 12'd3125;
    localparam logic [63:0] P_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic [31:0] H_OFFSET_T  = 32'd76800;
    localparam logic [31:0] H_ROUND_X   = 32'd16384;
    localparam logic [31:0] H_BIAS_M2   = 32'd32768;
    localparam logic [31:0] H_BIAS_M3   = 32'd2097152;
    localparam logic [31:0] H_ROUND_Y   = 32'd8192;
    localparam logic [31:0] H_MAX       = 32'd419430400;

    // channel payloads
    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } t_result;

    // humidity coefficients handed to the humidity lane
    typedef struct packed {
        logic        en;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [11:0] h4;
        logic [11:0] h5;
        logic [7:0]  h6;
    } t_hum_cal;

    // control bits that travel with a quotient
    typedef struct packed {
        logic vld;
        logic zero;
    } t_div_tag;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = $signed(x) >>> n;
    endfunction

endpackage

@@ rtl/core/esc_div.sv @@
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed divider, one quotient bit per stage. Quotient wraps at
// 64 bits; a zero divisor is flagged and the quotient is meaningless.
// ----------------------------------------------------------------------------
module esc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [esc_pkg::NUM_W-1:0]   i_num,
    input  logic [esc_pkg::DEN_W-1:0]   i_den,
    output esc_pkg::t_div_tag           o_tag,
    output logic [esc_pkg::NUM_W-1:0]   o_quo
);
    import esc_pkg::*;

    logic [DEN_W-1:0] r_rem [0:DIV_STEPS];
    logic [NUM_W-1:0] r_num [0:DIV_STEPS];
    logic [DEN_W-1:0] r_den [0:DIV_STEPS];
    logic [DIV_STEPS:0] r_vld;
    logic [DIV_STEPS:0] r_neg;
    logic [DIV_STEPS:0] r_zero;
    t_div_tag         r_tag;
    logic [NUM_W-1:0] r_quo;

    // entry: magnitudes and result sign
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= i_num[NUM_W-1] ? (NUM_W'(0) - i_num) : i_num;
        r_den[0] <= i_den[DEN_W-1] ? (DEN_W'(0) - i_den) : i_den;
    end

    // restoring steps
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [DEN_W:0] w_t;
        logic           w_ge;
        assign w_t  = {r_rem[k-1], r_num[k-1][NUM_W-1]};
        assign w_ge = (w_t >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? DEN_W'(w_t - {1'b0, r_den[k-1]}) : w_t[DEN_W-1:0];
            r_num[k] <= {r_num[k-1][NUM_W-2:0], w_ge};
            r_den[k] <= r_den[k-1];
        end
    end

    // sign and zero flags ride along; the sign stage applies the sign to the quotient
    always_ff @(posedge i_clk) begin
        r_neg  <= {r_neg[DIV_STEPS-1:0], i_num[NUM_W-1] ^ i_den[DEN_W-1]};
        r_zero <= {r_zero[DIV_STEPS-1:0], (i_den == '0)};
        r_quo  <= r_neg[DIV_STEPS] ? (NUM_W'(0) - r_num[DIV_STEPS]) : r_num[DIV_STEPS];
    end

    // valid chain and output tag
    always_ff @(posedge i_clk) begin
        r_tag.zero <= r_zero[DIV_STEPS];
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_tag.vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[DIV_STEPS-1:0], i_vld};
            r_tag.vld <= r_vld[DIV_STEPS];
        end
    end

    assign o_tag = r_tag;
    assign o_quo = r_quo;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_STEPS] && !r_zero[DIV_STEPS]) |-> (r_rem[DIV_STEPS] < r_den[DIV_STEPS]))
        else $error("divider remainder not below divisor");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##DIV_LAT o_tag.vld)
        else $error("divider beat lost");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && (i_den == '0)) |-> ##DIV_LAT (o_tag.vld && o_tag.zero))
        else $error("zero divisor not flagged");

endmodule

@@ rtl/core/esc_hum.sv @@
// ----------------------------------------------------------------------------
// esc_hum
// Humidity lane: 32-bit wrapping compensation, clamp, final scale and
// enable gate, at most one multiplier level per stage, nine stages.
// ----------------------------------------------------------------------------
module esc_hum (
    input  logic              i_clk,
    input  esc_pkg::t_hum_cal i_cal,
    input  logic [31:0]       i_v,
    input  logic [15:0]       i_rh,
    output logic [16:0]       o_hum
);
    import esc_pkg::*;

    logic [31:0] w_h2, w_h4, w_h5, w_h6, w_h3, w_h1;
    logic [31:0] r_m5, r_mv6, r_mv3;
    logic [15:0] r_rh;
    logic [31:0] w_xs, r_x2, r_m1, r_m2;
    logic [31:0] r_m12, r_x3;
    logic [31:0] w_m3, r_m3h2, r_x4;
    logic [31:0] r_y5, r_x5;
    logic [31:0] r_vv6;
    logic [31:0] w_w, r_ww7, r_vv7;
    logic [31:0] r_www8, r_vv8;
    logic [31:0] w_r, w_clamp;
    logic [16:0] r_hum;

    assign w_h1 = {24'd0, i_cal.h1};
    assign w_h2 = {{16{i_cal.h2[15]}}, i_cal.h2};
    assign w_h3 = {24'd0, i_cal.h3};
    assign w_h4 = {i_cal.h4, 20'd0};
    assign w_h5 = {{20{i_cal.h5[11]}}, i_cal.h5};
    assign w_h6 = {{24{i_cal.h6[7]}}, i_cal.h6};

    // H1: products of the temperature offset
    always_ff @(posedge i_clk) begin
        r_m5  <= i_v * w_h5;
        r_mv6 <= i_v * w_h6;
        r_mv3 <= i_v * w_h3;
        r_rh  <= i_rh;
    end

    // H2: raw term and the two factors
    assign w_xs = {2'd0, r_rh, 14'd0} - w_h4 - r_m5 + H_ROUND_X;
    always_ff @(posedge i_clk) begin
        r_x2 <= asr32(w_xs, 15);
        r_m1 <= asr32(r_mv6, 10);
        r_m2 <= asr32(r_mv3, 11) + H_BIAS_M2;
    end

    // H3
    always_ff @(posedge i_clk) begin
        r_m12 <= r_m1 * r_m2;
        r_x3  <= r_x2;
    end

    // H4
    assign w_m3 = asr32(r_m12, 10) + H_BIAS_M3;
    always_ff @(posedge i_clk) begin
        r_m3h2 <= w_m3 * w_h2;
        r_x4   <= r_x3;
    end

    // H5
    always_ff @(posedge i_clk) begin
        r_y5 <= asr32(r_m3h2 + H_ROUND_Y, 14);
        r_x5 <= r_x4;
    end

    // H6
    always_ff @(posedge i_clk) begin
        r_vv6 <= r_x5 * r_y5;
    end

    // H7: square term
    assign w_w = asr32(r_vv6, 15);
    always_ff @(posedge i_clk) begin
        r_ww7 <= w_w * w_w;
        r_vv7 <= r_vv6;
    end

    // H8
    always_ff @(posedge i_clk) begin
        r_www8 <= asr32(r_ww7, 7) * w_h1;
        r_vv8  <= r_vv7;
    end

    // H9: clamp, scale and enable gate
    assign w_r = r_vv8 - asr32(r_www8, 4);
    always_comb begin
        if (w_r[31]) begin
            w_clamp = '0;
        end else if (w_r > H_MAX) begin
            w_clamp = H_MAX;
        end else begin
            w_clamp = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hum <= i_cal.en ? w_clamp[28:12] : 17'd0;
    end

    assign o_hum = r_hum;

endmodule

@@ rtl/core/environmental_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// environmental_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
//
// Input: a sample beat is taken on a rising edge with start high and busy
// low. busy is low whenever the block is out of reset, so a new sample can
// be taken every cycle.
// Output: o_strobe marks one cycle in which o_result holds the result of
// one sample; results come out in sample order and cannot be held off.
// Throughput is one sample per cycle. Between the accepting edge and the
// edge that raises the strobe lie the 12 multiply / add stages of the
// pressure path, a 66-stage divider that resolves one quotient bit per
// stage and 6 stages after the divider; the result is taken at the edge
// after that. Temperature and humidity results are delayed to line up
// with pressure.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data in
// the same edge; unknown indexes are ignored. Write only while idle.
// Reset (synchronous, active low) clears the calibration registers and
// all valid bits; samples in flight are dropped.
// ----------------------------------------------------------------------------
module environmental_sensor_compensation (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  esc_pkg::t_sample                 i_sample,
    output logic                             o_strobe,
    output esc_pkg::t_result                 o_result,
    input  logic                             i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [esc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import esc_pkg::*;

    // calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_plo;
    logic [63:0] r_cal_phi;
    logic [47:0] r_cal_mix;
    logic [31:0] r_cal_hum;
    logic        r_hum_en;

    logic [15:0] w_t1, w_t2, w_t3;
    logic [15:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    t_hum_cal    w_hum_cal;

    logic w_accept;
    logic [FRONT_LAT:1] r_vld_f;
    logic [BACK_LAT:1]  r_vld_b;

    // stage registers
    logic [19:0] r_rp_d [1:9];
    logic [15:0] r_rh_d [1:TEMP_STAGE];
    logic signed [17:0] w_x1;
    logic signed [16:0] w_d;
    logic signed [33:0] w_m1, w_dd;
    logic [31:0] r_m1_s1, r_dd_s1;
    logic signed [35:0] w_m2;
    logic [31:0] r_v1_s2, r_m2_s2;
    logic [31:0] r_tf_s3;
    logic [31:0] w_tf5;
    logic [31:0] r_tc_s4, r_hv_s4;
    logic [32:0] r_a_s4;
    logic [63:0] w_al2;
    logic signed [48:0] w_ap5, w_ap2;
    logic [63:0] r_al2_s5;
    logic [30:0] r_al_s5;
    logic        r_neg_s5;
    logic signed [48:0] r_ap5_s5, r_ap2_s5;
    logic [63:0] r_aa_s6;
    logic signed [48:0] r_ap5_s6, r_ap2_s6;
    logic signed [48:0] w_lo6, w_lo3;
    logic [31:0] w_hi6, w_hi3;
    logic signed [48:0] r_lo6_s7, r_lo3_s7, r_ap5_s7, r_ap2_s7;
    logic [31:0] r_hi6_s7, r_hi3_s7;
    logic [63:0] r_aap6_s8, r_aap3_s8;
    logic signed [48:0] r_ap5_s8, r_ap2_s8;
    logic [63:0] r_b_s9, r_a1_s9;
    logic [20:0] w_pn;
    logic [63:0] r_t_s10, r_n0_s10;
    logic [47:0] r_tlo_s11;
    logic [31:0] r_thi_s11, r_nhi_s11;
    logic [43:0] r_nlo_s11;
    logic [63:0] w_prod;
    logic [DEN_W-1:0] r_den_s12;
    logic [NUM_W-1:0] r_num_s12;

    // divider and back end
    t_div_tag         w_div_tag;
    logic [NUM_W-1:0] w_quo;
    logic [63:0] w_ps;
    logic [63:0] r_ll_t1, r_q_t1;
    logic [31:0] r_hl_t1, r_hi8_t1;
    logic signed [48:0] w_lo8, r_lo8_t1;
    logic        r_zero_t1, r_zero_t2, r_zero_t3, r_zero_t4, r_zero_t5;
    logic [63:0] w_pb, r_sq_t2, r_b_t2, r_q_t2;
    logic signed [48:0] w_lo9, r_lo9_t3;
    logic [31:0] r_hi9_t3;
    logic [63:0] r_b_t3, r_q_t3;
    logic [63:0] r_a_t4, r_b_t4, r_q_t4;
    logic [63:0] r_s_t5;
    logic [31:0] w_press;

    // alignment of the other channels
    logic [31:0] r_tc_dly  [1:TC_DLY];
    logic [16:0] r_hum_dly [1:HUM_DLY];
    logic [16:0] w_hum;
    t_result     r_res;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t   <= '0;
            r_cal_plo <= '0;
            r_cal_phi <= '0;
            r_cal_mix <= '0;
            r_cal_hum <= '0;
            r_hum_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CALIB_T:   r_cal_t   <= i_cfg_data[47:0];
                REG_CALIB_PLO: r_cal_plo <= i_cfg_data;
                REG_CALIB_PHI: r_cal_phi <= i_cfg_data;
                REG_CALIB_MIX: r_cal_mix <= i_cfg_data[47:0];
                REG_CALIB_HUM: r_cal_hum <= i_cfg_data[31:0];
                REG_HUM_EN:    r_hum_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // coefficient fields
    assign w_t1 = r_cal_t[15:0];
    assign w_t2 = r_cal_t[31:16];
    assign w_t3 = r_cal_t[47:32];
    assign w_p1 = r_cal_plo[15:0];
    assign w_p2 = r_cal_plo[31:16];
    assign w_p3 = r_cal_plo[47:32];
    assign w_p4 = r_cal_plo[63:48];
    assign w_p5 = r_cal_phi[15:0];
    assign w_p6 = r_cal_phi[31:16];
    assign w_p7 = r_cal_phi[47:32];
    assign w_p8 = r_cal_phi[63:48];
    assign w_p9 = r_cal_mix[15:0];

    assign w_hum_cal.en = r_hum_en;
    assign w_hum_cal.h1 = r_cal_mix[23:16];
    assign w_hum_cal.h2 = r_cal_mix[39:24];
    assign w_hum_cal.h3 = r_cal_mix[47:40];
    assign w_hum_cal.h4 = r_cal_hum[11:0];
    assign w_hum_cal.h5 = r_cal_hum[23:12];
    assign w_hum_cal.h6 = r_cal_hum[31:24];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= '0;
            r_vld_b <= '0;
        end else begin
            r_vld_f <= {r_vld_f[FRONT_LAT-1:1], w_accept};
            r_vld_b <= {r_vld_b[BACK_LAT-1:1], w_div_tag.vld};
        end
    end

    // raw pressure / humidity ride along
    always_ff @(posedge i_clk) begin
        r_rp_d[1] <= i_sample.raw_pressure;
        for (int k = 2; k <= 9; k++) begin
            r_rp_d[k] <= r_rp_d[k-1];
        end
        r_rh_d[1] <= i_sample.raw_humidity;
        for (int k = 2; k <= TEMP_STAGE; k++) begin
            r_rh_d[k] <= r_rh_d[k-1];
        end
    end

    // S1: temperature products
    assign w_x1 = $signed({1'b0, i_sample.raw_temperature[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_d  = $signed({1'b0, i_sample.raw_temperature[19:4]}) - $signed({1'b0, w_t1});
    assign w_m1 = w_x1 * $signed(w_t2);
    assign w_dd = w_d * w_d;
    always_ff @(posedge i_clk) begin
        r_m1_s1 <= w_m1[31:0];
        r_dd_s1 <= w_dd[31:0];
    end

    // S2
    assign w_m2 = $signed(r_dd_s1[31:12]) * $signed(w_t3);
    always_ff @(posedge i_clk) begin
        r_v1_s2 <= asr32(r_m1_s1, 11);
        r_m2_s2 <= w_m2[31:0];
    end

    // S3: fine temperature
    always_ff @(posedge i_clk) begin
        r_tf_s3 <= r_v1_s2 + asr32(r_m2_s2, 14);
    end

    // S4: centi result and offsets for the other channels
    assign w_tf5 = {r_tf_s3[29:0], 2'd0} + r_tf_s3 + T_ROUND;
    always_ff @(posedge i_clk) begin
        r_tc_s4 <= asr32(w_tf5, 8);
        r_a_s4  <= {r_tf_s3[31], r_tf_s3} - P_OFFSET_T;
        r_hv_s4 <= r_tf_s3 - H_OFFSET_T;
    end

    // S5: square split into low word, linear terms
    assign w_al2 = r_a_s4[31:0] * r_a_s4[31:0];
    assign w_ap5 = $signed(r_a_s4) * $signed(w_p5);
    assign w_ap2 = $signed(r_a_s4) * $signed(w_p2);
    always_ff @(posedge i_clk) begin
        r_al2_s5 <= w_al2;
        r_al_s5  <= r_a_s4[30:0];
        r_neg_s5 <= r_a_s4[32];
        r_ap5_s5 <= w_ap5;
        r_ap2_s5 <= w_ap2;
    end

    // S6: sign correction of the square
    always_ff @(posedge i_clk) begin
        r_aa_s6  <= r_al2_s5 - (r_neg_s5 ? {r_al_s5, 33'd0} : 64'd0);
        r_ap5_s6 <= r_ap5_s5;
        r_ap2_s6 <= r_ap2_s5;
    end

    // S7: square times P6 / P3, two partial products each
    assign w_lo6 = $signed({1'b0, r_aa_s6[31:0]}) * $signed(w_p6);
    assign w_lo3 = $signed({1'b0, r_aa_s6[31:0]}) * $signed(w_p3);
    assign w_hi6 = r_aa_s6[63:32] * {{16{w_p6[15]}}, w_p6};
    assign w_hi3 = r_aa_s6[63:32] * {{16{w_p3[15]}}, w_p3};
    always_ff @(posedge i_clk) begin
        r_lo6_s7 <= w_lo6;
        r_lo3_s7 <= w_lo3;
        r_hi6_s7 <= w_hi6;
        r_hi3_s7 <= w_hi3;
        r_ap5_s7 <= r_ap5_s6;
        r_ap2_s7 <= r_ap2_s6;
    end

    // S8: merge partials
    always_ff @(posedge i_clk) begin
        r_aap6_s8 <= {{15{r_lo6_s7[48]}}, r_lo6_s7} + {r_hi6_s7, 32'd0};
        r_aap3_s8 <= {{15{r_lo3_s7[48]}}, r_lo3_s7} + {r_hi3_s7, 32'd0};
        r_ap5_s8  <= r_ap5_s7;
        r_ap2_s8  <= r_ap2_s7;
    end

    // S9: numerator offset and divisor seed
    always_ff @(posedge i_clk) begin
        r_b_s9  <= r_aap6_s8 + {r_ap5_s8[46:0], 17'd0} + {{13{w_p4[15]}}, w_p4, 35'd0};
        r_a1_s9 <= asr64(r_aap3_s8, 8) + {{3{r_ap2_s8[48]}}, r_ap2_s8, 12'd0};
    end

    // S10
    assign w_pn = P_BASE - {1'b0, r_rp_d[9]};
    always_ff @(posedge i_clk) begin
        r_t_s10  <= P_BIAS + r_a1_s9;
        r_n0_s10 <= {12'd0, w_pn, 31'd0} - r_b_s9;
    end

    // S11: times P1 and times 3125, split in words
    always_ff @(posedge i_clk) begin
        r_tlo_s11 <= r_t_s10[31:0] * w_p1;
        r_thi_s11 <= r_t_s10[63:32] * {16'd0, w_p1};
        r_nlo_s11 <= r_n0_s10[31:0] * P_SCALE;
        r_nhi_s11 <= r_n0_s10[63:32] * {20'd0, P_SCALE};
    end

    // S12: divisor and dividend
    assign w_prod = {16'd0, r_tlo_s11} + {r_thi_s11, 32'd0};
    always_ff @(posedge i_clk) begin
        r_den_s12 <= w_prod[63:33];
        r_num_s12 <= {20'd0, r_nlo_s11} + {r_nhi_s11, 32'd0};
    end

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld_f[FRONT_LAT]),
        .i_num   (r_num_s12),
        .i_den   (r_den_s12),
        .o_tag   (w_div_tag),
        .o_quo   (w_quo)
    );

    // T1: square of the scaled quotient, P8 term partials
    assign w_ps  = asr64(w_quo, 13);
    assign w_lo8 = $signed({1'b0, w_quo[31:0]}) * $signed(w_p8);
    always_ff @(posedge i_clk) begin
        r_ll_t1   <= w_ps[31:0] * w_ps[31:0];
        r_hl_t1   <= {{13{w_ps[50]}}, w_ps[50:32]} * w_ps[31:0];
        r_lo8_t1  <= w_lo8;
        r_hi8_t1  <= w_quo[63:32] * {{16{w_p8[15]}}, w_p8};
        r_q_t1    <= w_quo;
        r_zero_t1 <= w_div_tag.zero;
    end

    // T2
    assign w_pb = {{15{r_lo8_t1[48]}}, r_lo8_t1} + {r_hi8_t1, 32'd0};
    always_ff @(posedge i_clk) begin
        r_sq_t2   <= r_ll_t1 + {r_hl_t1[30:0], 33'd0};
        r_b_t2    <= asr64(w_pb, 19);
        r_q_t2    <= r_q_t1;
        r_zero_t2 <= r_zero_t1;
    end

    // T3: times P9
    assign w_lo9 = $signed({1'b0, r_sq_t2[31:0]}) * $signed(w_p9);
    always_ff @(posedge i_clk) begin
        r_lo9_t3  <= w_lo9;
        r_hi9_t3  <= r_sq_t2[63:32] * {{16{w_p9[15]}}, w_p9};
        r_b_t3    <= r_b_t2;
        r_q_t3    <= r_q_t2;
        r_zero_t3 <= r_zero_t2;
    end

    // T4
    always_ff @(posedge i_clk) begin
        r_a_t4    <= asr64({{15{r_lo9_t3[48]}}, r_lo9_t3} + {r_hi9_t3, 32'd0}, 25);
        r_b_t4    <= r_b_t3;
        r_q_t4    <= r_q_t3;
        r_zero_t4 <= r_zero_t3;
    end

    // T5
    always_ff @(posedge i_clk) begin
        r_s_t5    <= r_q_t4 + r_a_t4 + r_b_t4;
        r_zero_t5 <= r_zero_t4;
    end

    // T6: final pressure, only the low word is kept
    assign w_press = r_s_t5[39:8] + {{12{w_p7[15]}}, w_p7, 4'd0};

    esc_hum u_hum (
        .i_clk (i_clk),
        .i_cal (w_hum_cal),
        .i_v   (r_hv_s4),
        .i_rh  (r_rh_d[TEMP_STAGE]),
        .o_hum (w_hum)
    );

    // delay lines for temperature and humidity
    always_ff @(posedge i_clk) begin
        r_tc_dly[1] <= r_tc_s4;
        for (int k = 2; k <= TC_DLY; k++) begin
            r_tc_dly[k] <= r_tc_dly[k-1];
        end
        r_hum_dly[1] <= w_hum;
        for (int k = 2; k <= HUM_DLY; k++) begin
            r_hum_dly[k] <= r_hum_dly[k-1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_res.temperature_centi <= r_tc_dly[TC_DLY];
        r_res.pressure_q24_8    <= r_zero_t5 ? 32'd0 : w_press;
        r_res.humidity_q22_10   <= r_hum_dly[HUM_DLY];
    end

    assign o_strobe = r_vld_b[BACK_LAT];
    assign o_result = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##TOTAL_LAT o_strobe)
        else $error("sample beat lost in pipeline");

    a_hum_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_hum_en) |-> (o_result.humidity_q22_10 == '0))
        else $error("humidity nonzero while disabled");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_tag.vld && w_div_tag.zero) |-> ##BACK_LAT
        (o_strobe && (o_result.pressure_q24_8 == '0)))
        else $error("pressure nonzero on zero divisor");

endmodule
